// ----- rtl/lnr_pkg.sv -----
// ----------------------------------------------------------------------------
// lnr_pkg
// Shared types and constants for the layer normalization row core.
// ----------------------------------------------------------------------------
package lnr_pkg;

    // Configuration register indexes
    typedef logic [0:0] t_cfg_idx;
    localparam t_cfg_idx REG_ROW_LENGTH = 1'b0;
    localparam t_cfg_idx REG_EPSILON    = 1'b1;

    // Field widths
    localparam int DATA_W = 16;
    localparam int LEN_W  = 7;
    localparam int EPS_W  = 24;
    localparam int SUM_W  = 23;

    // Shared multiplier operand width
    localparam int MUL_W = 32;

    // Shared divider: dividend and divisor widths
    localparam int DIVN_W = 56;
    localparam int DIVD_W = 19;

    // Newton iteration constants, Q2.30
    localparam logic [31:0] SEED_LO   = 32'h3700_0000;
    localparam logic [31:0] SEED_HI   = 32'h2600_0000;
    localparam logic [33:0] THREE_Q30 = 34'h0_C000_0000;

    // Reset values of the configuration registers
    localparam logic [LEN_W-1:0] ROW_LENGTH_RST = 7'd64;
    localparam logic [EPS_W-1:0] EPSILON_RST    = 24'd168;

endpackage

// ----- rtl/lnr_mul.sv -----
// ----------------------------------------------------------------------------
// lnr_mul
// Shared unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module lnr_mul (
    input  logic                          i_clk,
    input  logic [lnr_pkg::MUL_W-1:0]     i_a,
    input  logic [lnr_pkg::MUL_W-1:0]     i_b,
    output logic [2*lnr_pkg::MUL_W-1:0]   o_prod
);

    logic [2*lnr_pkg::MUL_W-1:0] r_prod;
    logic [2*lnr_pkg::MUL_W-1:0] n_prod;

    // product lands in the cycle after the operands
    assign n_prod = i_a * i_b;

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
    end

    assign o_prod = r_prod;

endmodule

// ----- rtl/lnr_div.sv -----
// ----------------------------------------------------------------------------
// lnr_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lnr_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [lnr_pkg::DIVN_W-1:0]    i_dividend,
    input  logic [lnr_pkg::DIVD_W-1:0]    i_divisor,
    output logic                          o_done,
    output logic [lnr_pkg::DIVN_W-1:0]    o_quot
);

    localparam int NW = lnr_pkg::DIVN_W;
    localparam int DW = lnr_pkg::DIVD_W;
    localparam int CW = $clog2(NW);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [NW-1:0] r_quo;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_div;

    logic [DW:0]   rem_sh;
    logic          ge;
    logic [DW-1:0] n_rem;

    // one shift-subtract step
    always_comb begin
        rem_sh = {r_rem, r_quo[NW-1]};
        ge     = (rem_sh >= {1'b0, r_div});
        n_rem  = ge ? DW'(rem_sh - {1'b0, r_div}) : rem_sh[DW-1:0];
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(NW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[NW-2:0], ge};
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

// ----- rtl/layer_normalization_row_core.sv -----
// ----------------------------------------------------------------------------
// layer_normalization_row_core
// Layer normalization of one row of signed Q4.12 elements.
//
// Usage: the input channel (i_in_valid / o_in_stall) takes one element per
// transfer with its column's gamma and beta; elements are stored in a 48-bit
// wide row memory. While a row fills, the input is never stalled. When
// row_length elements are held, the block stalls its input and runs a
// sequencer around one shared 32x32 multiplier and one bit-serial divider:
// the deviation sum of squares element by element, the variance divide,
// mantissa normalization and the Newton steps. Each result then needs a
// 56-step divide by the row length. Results leave on o_out_valid /
// i_out_stall with o_last_of_row on the final column; a stalled result
// holds in the output register and the sequencer waits. The block takes no
// new element until the last result of the row is loaded for output.
// Configuration (i_cfg_valid / o_cfg_ready) is always ready; write it only
// while idle. Synchronous reset empties the row, drops output valid and sets
// row_length to 64 and epsilon to 168. The row memory needs no clearing.
// ----------------------------------------------------------------------------
module layer_normalization_row_core #(
    parameter int MAX_COLUMNS  = 64,
    parameter int NEWTON_STEPS = 4
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // input element channel
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic signed [lnr_pkg::DATA_W-1:0]  i_value,
    input  logic signed [lnr_pkg::DATA_W-1:0]  i_gamma_scale,
    input  logic signed [lnr_pkg::DATA_W-1:0]  i_beta_shift,
    // result channel
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic signed [lnr_pkg::DATA_W-1:0]  o_normalized,
    output logic                               o_last_of_row,
    // configuration write channel
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  lnr_pkg::t_cfg_idx                  i_cfg_index,
    input  logic [lnr_pkg::EPS_W-1:0]          i_cfg_data
);

    localparam int AW = $clog2(MAX_COLUMNS);
    localparam int CW = $clog2(MAX_COLUMNS + 1);
    localparam int SW = $clog2(NEWTON_STEPS);
    localparam int DATA_W = lnr_pkg::DATA_W;
    localparam int LEN_W  = lnr_pkg::LEN_W;
    localparam int MUL_W  = lnr_pkg::MUL_W;
    localparam int DIVN_W = lnr_pkg::DIVN_W;
    localparam int DIVD_W = lnr_pkg::DIVD_W;
    localparam int SUM_W  = lnr_pkg::SUM_W;

    typedef enum logic [4:0] {
        S_IDLE, S_C1, S_C2, S_C3,
        S_V_RD, S_V_D, S_V_MUL, S_V_ACC,
        S_VDIV_GO, S_VDIV_WAIT, S_NORM,
        S_N_YY, S_N_MY, S_N_T, S_N_YT, S_N_Y,
        S_O_RD, S_O_D, S_O_MUL, S_ODIV_GO, S_ODIV_WAIT,
        S_O_MLO, S_O_MHI, S_O_SUM, S_O_RND, S_O_EMIT
    } t_state;

    // registers
    t_state                    r_state;
    logic [LEN_W-1:0]          r_row_len;
    logic [lnr_pkg::EPS_W-1:0] r_eps;
    logic [CW-1:0]             r_fill;
    logic signed [SUM_W-1:0]   r_sum;
    logic [CW-1:0]             r_n;
    logic signed [SUM_W-1:0]   r_row_sum;
    logic [AW-1:0]             r_i;
    logic [DIVD_W-1:0]         r_n3;
    logic [DIVN_W-1:0]         r_sq;
    logic [SUM_W-1:0]          r_ad;
    logic                      r_neg;
    logic [DATA_W-1:0]         r_ag;
    logic signed [DATA_W-1:0]  r_b;
    logic [31:0]               r_m;
    logic [3:0]                r_k;
    logic [31:0]               r_y;
    logic [31:0]               r_t;
    logic [SW-1:0]             r_step;
    logic [DIVN_W-1:0]         r_q;
    logic [63:0]               r_acc;
    logic [33:0]               r_qr;
    logic                      r_ovalid;
    logic signed [DATA_W-1:0]  r_onorm;
    logic                      r_olast;
    logic [3*DATA_W-1:0]       r_rdata;

    // row memory: value, gamma, beta
    logic [3*DATA_W-1:0]       mem [MAX_COLUMNS];

    // shared units
    logic [MUL_W-1:0]          mul_a;
    logic [MUL_W-1:0]          mul_b;
    logic [2*MUL_W-1:0]        prod;
    logic                      div_start;
    logic [DIVN_W-1:0]         div_n;
    logic [DIVD_W-1:0]         div_d;
    logic                      div_done;
    logic [DIVN_W-1:0]         div_q;

    // combinational helpers
    logic                      in_acc;
    logic [CW-1:0]             fill_nx;
    logic signed [SUM_W-1:0]   sum_nx;
    logic [LEN_W-1:0]          lim;
    logic signed [23:0]        nx;
    logic signed [23:0]        d_w;
    logic [SUM_W-1:0]          ad_w;
    logic signed [DATA_W-1:0]  rd_x;
    logic signed [DATA_W-1:0]  rd_g;
    logic signed [DATA_W-1:0]  rd_b;
    logic [16:0]               ag_w;
    logic [31:0]               v_w;
    logic [33:0]               t_w;
    logic [31:0]               tc_w;
    logic [63:0]               rnd_sum;
    logic [63:0]               rnd_sh;
    logic signed [35:0]        sr_w;
    logic signed [35:0]        o_w;
    logic signed [DATA_W-1:0]  sat_w;
    logic                      out_free;
    logic                      last_i;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_free = !r_ovalid || !i_out_stall;
    assign last_i   = (r_i == AW'(r_n - 1'b1));

    // row bookkeeping on accept
    always_comb begin
        fill_nx = r_fill + 1'b1;
        sum_nx  = r_sum + SUM_W'(i_value);
        if (r_row_len == '0) begin
            lim = LEN_W'(1);
        end else if (r_row_len > LEN_W'(MAX_COLUMNS)) begin
            lim = LEN_W'(MAX_COLUMNS);
        end else begin
            lim = r_row_len;
        end
    end

    // deviation d = n*x - sum from the read data
    always_comb begin
        rd_x = r_rdata[3*DATA_W-1:2*DATA_W];
        rd_g = r_rdata[2*DATA_W-1:DATA_W];
        rd_b = r_rdata[DATA_W-1:0];
        nx   = $signed({{(24-CW){1'b0}}, r_n}) * $signed({{8{rd_x[DATA_W-1]}}, rd_x});
        d_w  = nx - $signed({r_row_sum[SUM_W-1], r_row_sum});
        ad_w = d_w[23] ? SUM_W'(-d_w) : SUM_W'(d_w);
        ag_w = rd_g[DATA_W-1] ? 17'(-$signed({rd_g[DATA_W-1], rd_g}))
                              : 17'({1'b0, rd_g});
    end

    // variance plus epsilon, Newton clamp, rounding and saturation
    always_comb begin
        v_w = div_q[31:0] + 32'(r_eps);
        if (v_w == '0) begin
            v_w = 32'd1;
        end
        t_w  = prod[63:30];
        tc_w = (t_w > lnr_pkg::THREE_Q30) ? lnr_pkg::THREE_Q30[31:0] : t_w[31:0];
        rnd_sum = r_acc + (64'd1 << (6'd29 + {2'b00, r_k}));
        rnd_sh  = rnd_sum >> (6'd30 + {2'b00, r_k});
        sr_w = r_neg ? -$signed({2'b00, r_qr}) : $signed({2'b00, r_qr});
        o_w  = sr_w + 36'(r_b);
        if (o_w > 36'sd32767) begin
            sat_w = 16'sh7FFF;
        end else if (o_w < -36'sd32768) begin
            sat_w = 16'sh8000;
        end else begin
            sat_w = o_w[DATA_W-1:0];
        end
    end

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            S_C1: begin
                mul_a = MUL_W'(r_n);
                mul_b = MUL_W'(r_n);
            end
            S_C2: begin
                mul_a = prod[MUL_W-1:0];
                mul_b = MUL_W'(r_n);
            end
            S_V_MUL: begin
                mul_a = MUL_W'(r_ad);
                mul_b = MUL_W'(r_ad);
            end
            S_N_YY: begin
                mul_a = r_y;
                mul_b = r_y;
            end
            S_N_MY: begin
                mul_a = r_m;
                mul_b = prod[61:30];
            end
            S_N_YT: begin
                mul_a = r_y;
                mul_b = r_t;
            end
            S_O_MUL: begin
                mul_a = MUL_W'(r_ad);
                mul_b = r_y;
            end
            S_O_MLO: begin
                mul_a = r_q[31:0];
                mul_b = MUL_W'(r_ag);
            end
            S_O_MHI: begin
                mul_a = MUL_W'(r_q[DIVN_W-1:32]);
                mul_b = MUL_W'(r_ag);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // shared divider operand select
    always_comb begin
        div_start = (r_state == S_VDIV_GO) || (r_state == S_ODIV_GO);
        if (r_state == S_VDIV_GO) begin
            div_n = r_sq;
            div_d = r_n3;
        end else begin
            div_n = prod[DIVN_W-1:0];
            div_d = DIVD_W'(r_n);
        end
    end

    lnr_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    lnr_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_n),
        .i_divisor  (div_d),
        .o_done     (div_done),
        .o_quot     (div_q)
    );

    // row memory: write on accept, registered read at the walk index
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            mem[r_fill[AW-1:0]] <= {i_value, i_gamma_scale, i_beta_shift};
        end
        r_rdata <= mem[r_i];
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_len <= lnr_pkg::ROW_LENGTH_RST;
            r_eps     <= lnr_pkg::EPSILON_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                lnr_pkg::REG_ROW_LENGTH: r_row_len <= i_cfg_data[LEN_W-1:0];
                lnr_pkg::REG_EPSILON:    r_eps     <= i_cfg_data;
                default:                 r_eps     <= r_eps;
            endcase
        end
    end

    // sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_fill   <= '0;
            r_sum    <= '0;
            r_ovalid <= 1'b0;
            r_i      <= '0;
            r_step   <= '0;
        end else begin
            // the emit step reloads the output register itself
            if (r_ovalid && !i_out_stall && (r_state != S_O_EMIT)) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        if (LEN_W'(fill_nx) >= lim) begin
                            r_n       <= fill_nx;
                            r_row_sum <= sum_nx;
                            r_fill    <= '0;
                            r_sum     <= '0;
                            r_i       <= '0;
                            r_sq      <= '0;
                            r_state   <= S_C1;
                        end else begin
                            r_fill <= fill_nx;
                            r_sum  <= sum_nx;
                        end
                    end
                end
                S_C1: r_state <= S_C2;
                S_C2: r_state <= S_C3;
                S_C3: begin
                    r_n3    <= prod[DIVD_W-1:0];
                    r_state <= S_V_RD;
                end
                // sum of squared deviations
                S_V_RD: r_state <= S_V_D;
                S_V_D: begin
                    r_ad    <= ad_w;
                    r_state <= S_V_MUL;
                end
                S_V_MUL: r_state <= S_V_ACC;
                S_V_ACC: begin
                    r_sq <= r_sq + prod[DIVN_W-1:0];
                    if (last_i) begin
                        r_i     <= '0;
                        r_state <= S_VDIV_GO;
                    end else begin
                        r_i     <= r_i + 1'b1;
                        r_state <= S_V_RD;
                    end
                end
                S_VDIV_GO: r_state <= S_VDIV_WAIT;
                S_VDIV_WAIT: begin
                    if (div_done) begin
                        r_m     <= v_w;
                        r_k     <= 4'd15;
                        r_state <= S_NORM;
                    end
                end
                // mantissa into [1,4) by steps of two bits
                S_NORM: begin
                    if (r_m[31:30] == 2'b00) begin
                        r_m <= {r_m[29:0], 2'b00};
                        r_k <= r_k - 1'b1;
                    end else begin
                        r_y     <= r_m[31] ? lnr_pkg::SEED_HI : lnr_pkg::SEED_LO;
                        r_step  <= '0;
                        r_state <= S_N_YY;
                    end
                end
                // Newton step for 1/sqrt
                S_N_YY: r_state <= S_N_MY;
                S_N_MY: r_state <= S_N_T;
                S_N_T: begin
                    r_t     <= lnr_pkg::THREE_Q30[31:0] - tc_w;
                    r_state <= S_N_YT;
                end
                S_N_YT: r_state <= S_N_Y;
                S_N_Y: begin
                    r_y <= prod[62:31];
                    if (r_step == SW'(NEWTON_STEPS - 1)) begin
                        r_i     <= '0;
                        r_state <= S_O_RD;
                    end else begin
                        r_step  <= r_step + 1'b1;
                        r_state <= S_N_YY;
                    end
                end
                // output walk
                S_O_RD: r_state <= S_O_D;
                S_O_D: begin
                    r_ad    <= ad_w;
                    r_neg   <= d_w[23] ^ rd_g[DATA_W-1];
                    r_ag    <= ag_w[DATA_W-1:0];
                    r_b     <= rd_b;
                    r_state <= S_O_MUL;
                end
                S_O_MUL:   r_state <= S_ODIV_GO;
                S_ODIV_GO: r_state <= S_ODIV_WAIT;
                S_ODIV_WAIT: begin
                    if (div_done) begin
                        r_q     <= div_q;
                        r_state <= S_O_MLO;
                    end
                end
                S_O_MLO: r_state <= S_O_MHI;
                S_O_MHI: begin
                    r_acc   <= prod;
                    r_state <= S_O_SUM;
                end
                S_O_SUM: begin
                    r_acc   <= r_acc + {prod[31:0], 32'd0};
                    r_state <= S_O_RND;
                end
                S_O_RND: begin
                    r_qr    <= rnd_sh[33:0];
                    r_state <= S_O_EMIT;
                end
                S_O_EMIT: begin
                    if (out_free) begin
                        r_ovalid <= 1'b1;
                        r_onorm  <= sat_w;
                        r_olast  <= last_i;
                        if (last_i) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_i     <= r_i + 1'b1;
                            r_state <= S_O_RD;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall    = (r_state != S_IDLE);
    assign o_out_valid   = r_ovalid;
    assign o_normalized  = r_onorm;
    assign o_last_of_row = r_olast;
    assign o_cfg_ready   = 1'b1;

    // checks
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_fill < CW'(MAX_COLUMNS)))
        else $error("row fill count out of range while idle");

    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == S_O_EMIT))
        else $error("result raised outside the emit step");

    a_div_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_VDIV_WAIT || r_state == S_ODIV_WAIT))
        else $error("divider finished with no one waiting");

    a_mant_norm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_N_YY) |-> (r_m[31:30] != 2'b00))
        else $error("Newton step on an unnormalized mantissa");

endmodule

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for layer_normalization_row_core. Elements are sent with
// random gaps. An in-bench fixed-point model of the row mean, the variance,
// the Newton inverse root and the scale and offset step predicts every result.
// The result port is stalled at random, and once for a long stretch.
// Phases change the row length and epsilon between rows. Their settings
// include the extremes and the out-of-range lengths.
// ----------------------------------------------------------------------------
module tb;

    localparam int COLUMNS   = 64;
    localparam int NEWTON_N  = 4;
    localparam int CYC_LIMIT = 1000000;
    localparam int N_ITEMS   = 350;

    typedef struct packed {
        logic signed [lnr_pkg::DATA_W-1:0] norm;
        logic                              last;
    } t_norm_result;

    // Row predictor and result scoreboard
    class norm_scoreboard;
        bit [lnr_pkg::DATA_W-1:0] row_x[COLUMNS];
        bit [lnr_pkg::DATA_W-1:0] row_g[COLUMNS];
        bit [lnr_pkg::DATA_W-1:0] row_b[COLUMNS];
        int unsigned              fill;
        longint                   row_sum;
        bit [lnr_pkg::LEN_W-1:0]  row_len;
        bit [lnr_pkg::EPS_W-1:0]  eps;
        t_norm_result             pending_q[$];
        int                       errors;
        int                       results;
        int                       rows;

        function new();
            fill    = 0;
            row_sum = 0;
            row_len = lnr_pkg::ROW_LENGTH_RST;
            eps     = lnr_pkg::EPSILON_RST;
            errors  = 0;
            results = 0;
            rows    = 0;
        endfunction

        task report(input string msg);
            $display("MISMATCH @%0t: %s", $time, msg);
            errors++;
        endtask

        function void set_reg(input lnr_pkg::t_cfg_idx idx,
                              input bit [lnr_pkg::EPS_W-1:0] data);
            if (idx == lnr_pkg::REG_ROW_LENGTH) row_len = data[lnr_pkg::LEN_W-1:0];
            else eps = data;
        endfunction

        function int pending();
            return pending_q.size();
        endfunction

        // Store one element; when the row closes, queue its normalized columns
        function void note_element(input logic signed [lnr_pkg::DATA_W-1:0] x, g, b);
            int unsigned idx, lim, n;
            int p, k, i, s;
            longint d, r, o;
            longint unsigned a, sq, v, m, y, y2, t, q, ag;
            t_norm_result res;
            idx = (fill >= COLUMNS) ? COLUMNS - 1 : fill;
            row_x[idx] = x;
            row_g[idx] = g;
            row_b[idx] = b;
            row_sum += longint'(x);
            fill = idx + 1;
            lim = row_len;
            if (lim < 1) lim = 1;
            if (lim > COLUMNS) lim = COLUMNS;
            if (fill < lim) return;

            n = fill;
            sq = 0;
            for (i = 0; i < n; i++) begin
                d = longint'(n) * longint'($signed(row_x[i])) - row_sum;
                a = (d < 0) ? -d : d;
                sq += a * a;
            end
            v = sq / (longint'(n) * n * n) + eps;
            if (v == 0) v = 1;   // zero variance with zero epsilon

            // normalize to a Q2.30 mantissa in [1,4)
            p = 0;
            while (p < 63 && (v >> (p + 1)) != 0) p++;
            k = p / 2;
            m = v << (30 - 2 * k);
            y = (m < (64'd1 << 31)) ? 64'(lnr_pkg::SEED_LO) : 64'(lnr_pkg::SEED_HI);
            for (s = 0; s < NEWTON_N; s++) begin
                y2 = (y * y) >> 30;
                t = (m * y2) >> 30;
                if (t > (64'd3 << 30)) t = 64'd3 << 30;
                y = (y * ((64'd3 << 30) - t)) >> 31;
            end

            for (i = 0; i < n; i++) begin
                d = longint'(n) * longint'($signed(row_x[i])) - row_sum;
                a = (d < 0) ? -d : d;
                ag = ($signed(row_g[i]) < 0) ? -longint'($signed(row_g[i]))
                                             : longint'($signed(row_g[i]));
                q = ((a * y) / n) * ag;
                q = (q + (64'd1 << (29 + k))) >> (30 + k);
                r = q;
                if ((d < 0) != ($signed(row_g[i]) < 0)) r = -r;
                o = r + longint'($signed(row_b[i]));
                if (o > 32767) o = 32767;
                if (o < -32768) o = -32768;
                res.norm = o[lnr_pkg::DATA_W-1:0];
                res.last = (i == n - 1);
                pending_q.push_back(res);
            end
            fill = 0;
            row_sum = 0;
            rows++;
        endfunction

        task check_result(input logic signed [lnr_pkg::DATA_W-1:0] norm, input logic last);
            t_norm_result exp_r;
            results++;
            if (pending_q.size() == 0) begin
                report($sformatf("unexpected result %0d last %0b", norm, last));
                return;
            end
            exp_r = pending_q.pop_front();
            if (norm !== exp_r.norm)
                report($sformatf("normalized %0d, want %0d", norm, exp_r.norm));
            if (last !== exp_r.last)
                report($sformatf("last_of_row %0b, want %0b", last, exp_r.last));
        endtask
    endclass

    logic                              clk;
    logic                              rst_n;
    logic                              in_valid;
    logic                              in_stall;
    logic signed [lnr_pkg::DATA_W-1:0] value;
    logic signed [lnr_pkg::DATA_W-1:0] gamma_scale;
    logic signed [lnr_pkg::DATA_W-1:0] beta_shift;
    logic                              out_valid;
    logic                              out_stall;
    logic signed [lnr_pkg::DATA_W-1:0] normalized;
    logic                              last_of_row;
    logic                              cfg_valid;
    logic                              cfg_ready;
    lnr_pkg::t_cfg_idx                 cfg_index;
    logic [lnr_pkg::EPS_W-1:0]         cfg_data;

    norm_scoreboard sb;
    int  n_sent;
    int  n_cycles = 0;
    bit  quiet;
    bit  long_hold_done;
    logic signed [lnr_pkg::DATA_W-1:0] center;

    layer_normalization_row_core u_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_value       (value),
        .i_gamma_scale (gamma_scale),
        .i_beta_shift  (beta_shift),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_normalized  (normalized),
        .o_last_of_row (last_of_row),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int draw_gap();
        return quiet ? 0 : $urandom_range(0, 10);
    endfunction

    // Send one element and wait for its transfer
    task automatic send_element(input logic signed [lnr_pkg::DATA_W-1:0] x, g, b);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid    = 1'b1;
        value       = x;
        gamma_scale = g;
        beta_shift  = b;
        do @(posedge clk); while (in_stall);
        sb.note_element(x, g, b);
        n_sent++;
        @(negedge clk);
    endtask

    task automatic write_reg(input lnr_pkg::t_cfg_idx idx,
                             input logic [lnr_pkg::EPS_W-1:0] data);
        in_valid  = 1'b0;
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        do @(posedge clk); while (!cfg_ready);
        sb.set_reg(idx, data);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Wait for all results, then let a row that produced none settle
    task automatic wait_idle();
        in_valid = 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (100) @(posedge clk);
        @(negedge clk);
    endtask

    // Random element: clustered rows mostly, some flat rows, some full range
    task automatic send_random();
        int mode;
        logic signed [lnr_pkg::DATA_W-1:0] x, g;
        mode = $urandom_range(0, 3);
        if (mode == 0) x = 16'($urandom);
        else if (mode == 3) x = center;
        else x = center + $signed(16'($urandom_range(0, 1023))) - 16'sd512;
        if ($urandom_range(0, 1)) g = 16'($urandom);
        else g = $signed(16'($urandom_range(0, 8191))) - 16'sd4096;
        send_element(x, g, 16'($urandom));
    endtask

    // Result monitor
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) sb.check_result(normalized, last_of_row);
    end

    // Result-side stall, with one long hold-off to back the block up
    initial begin
        int w;
        out_stall = 1'b1;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (!long_hold_done && sb.results >= 40) begin
                long_hold_done = 1'b1;
                out_stall = 1'b1;
                repeat (600) @(negedge clk);
            end
            w = draw_gap();
            out_stall = (w != 0);
            repeat (w) @(negedge clk);
            out_stall = 1'b0;
            do @(posedge clk); while (!(out_valid && !out_stall));
        end
    end

    // Cycle limit
    always @(posedge clk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles > CYC_LIMIT) begin
            $display("timeout after %0d cycles", n_cycles);
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        int plen[12];
        int ph, eff, cnt, i;
        logic [lnr_pkg::EPS_W-1:0] e;
        plen = '{8, 1, 0, 5, 64, 2, 127, 3, 100, 16, 12, 4};
        sb = new();
        n_sent = 0;
        quiet = 1'b0;
        long_hold_done = 1'b0;
        center = '0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        value = '0;
        gamma_scale = '0;
        beta_shift = '0;
        cfg_valid = 1'b0;
        cfg_index = lnr_pkg::REG_ROW_LENGTH;
        cfg_data = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // single-column rows: deviation is zero, result is beta
        write_reg(lnr_pkg::REG_ROW_LENGTH, 24'd1);
        write_reg(lnr_pkg::REG_EPSILON, 24'd0);
        send_element(16'sh7fff, 16'sh7fff, 16'sh7fff);
        send_element(-16'sh8000, -16'sh8000, -16'sh8000);
        send_element(16'sd0, 16'sd0, 16'sd0);
        send_element(-16'sd1, -16'sd1, -16'sd1);
        wait_idle();
        // flat row with zero epsilon, then saturating rows
        write_reg(lnr_pkg::REG_ROW_LENGTH, 24'd2);
        send_element(16'sd100, 16'sd4096, 16'sd0);
        send_element(16'sd100, 16'sd4096, 16'sd5);
        send_element(16'sh7fff, 16'sh7fff, 16'sd0);
        send_element(-16'sh8000, -16'sh8000, 16'sd0);
        send_element(-16'sh8000, 16'sd4096, 16'sh7fff);
        send_element(16'sh7fff, -16'sd4096, -16'sh8000);
        wait_idle();
        // length lowered below the fill: row closes on the next element
        write_reg(lnr_pkg::REG_ROW_LENGTH, 24'd4);
        write_reg(lnr_pkg::REG_EPSILON, 24'hffffff);
        send_element(16'sd1000, 16'sd4096, 16'sd0);
        send_element(-16'sd2000, 16'sd8192, 16'sd100);
        send_element(16'sd300, -16'sd4096, -16'sd100);
        wait_idle();
        write_reg(lnr_pkg::REG_ROW_LENGTH, 24'd2);
        send_element(16'sd4000, 16'sd2048, 16'sd50);
        wait_idle();

        // random phases
        for (ph = 0; n_sent < N_ITEMS; ph++) begin
            quiet = (ph % 4 == 2);
            if (ph < 12) begin
                eff = plen[ph];
                e = (ph % 3 == 0) ? 24'd168 : (ph % 3 == 1) ? 24'd0 : 24'hffffff;
                if (ph == 5) e = 24'($urandom_range(0, 24'hffffff));
            end else begin
                eff = $urandom_range(1, 24);
                e = ($urandom_range(0, 3) == 0) ? 24'd0 : 24'($urandom_range(0, 4096));
            end
            write_reg(lnr_pkg::REG_ROW_LENGTH, 24'(eff));
            write_reg(lnr_pkg::REG_EPSILON, e);
            if (eff < 1) eff = 1;
            if (eff > COLUMNS) eff = COLUMNS;
            cnt = (eff >= 32) ? eff : eff * $urandom_range(1, 4);
            if ($urandom_range(0, 3) == 0) cnt += $urandom_range(0, eff - 1);
            center = 16'($urandom);
            for (i = 0; i < cnt; i++) send_random();
            wait_idle();
        end

        $display("sent %0d elements in %0d rows, checked %0d results",
                 n_sent, sb.rows, sb.results);
        $display("covered lengths 0..127, epsilon 0 to max, long output hold-off");
        if (sb.pending() != 0)
            sb.report($sformatf("%0d results never arrived", sb.pending()));
        if (sb.errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule
